@@ design/fixed_key_value_table_core_defines.svh @@
// assertion macros for the key/value table core
`ifndef FIXED_KEY_VALUE_TABLE_CORE_DEFINES_SVH
`define FIXED_KEY_VALUE_TABLE_CORE_DEFINES_SVH

// property must hold at every edge out of reset
`define KVT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("kvt check failed");

// condition must never be seen out of reset
`define KVT_ASSERT_NEVER(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(cond)) \
      else $error("kvt forbidden condition");

`endif

@@ design/kvt_pkg.sv @@
// shared constants, types and control structs of the key/value table
`default_nettype none

package kvt_pkg;

   localparam int KEY_BYTES   = 8;
   localparam int VALUE_BYTES = 8;
   localparam int ENTRIES     = 16;

   localparam int DATA_W   = 64;
   localparam int LEN_IN_W = 8;
   localparam int LEN_W    = 4;
   localparam int CNT_W    = $clog2(ENTRIES + 1);
   localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam logic [7:0] PAD_BYTE = 8'h20;

   typedef enum logic [1:0] {
      OP_PUT = 2'd0,
      OP_GET = 2'd1,
      OP_DEL = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2,
      ST_TOO_LONG  = 2'd3
   } rsp_status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SEARCH,
      S_PUT_UPD,
      S_PUT_NEW,
      S_GET_RD,
      S_DEL_RD,
      S_DEL_WR,
      S_RESP
   } state_type;

   typedef enum logic {
      RD_SLOT,
      RD_LAST
   } rd_sel_type;

   typedef enum logic {
      WR_REQ,
      WR_MOVE
   } wr_src_type;

   typedef struct packed {
      logic           accept;
      logic           search;
      logic           rd_en;
      rd_sel_type     rd_sel;
      logic           wr_en;
      wr_src_type     wr_src;
      logic           count_inc;
      logic           count_dec;
      logic           rsp_load;
      rsp_status_type rsp_status;
      logic           rsp_read;
   } kvt_cmd_type;

   typedef struct packed {
      logic       hit;
      logic       miss;
      logic       full;
      logic [1:0] req_op;
      logic       req_too_long;
      logic       rsp_free;
   } kvt_sts_type;

endpackage

`default_nettype wire

@@ design/kvt_req_if.sv @@
// request channel interface
`default_nettype none

interface kvt_req_if import kvt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [1:0]          op;
   logic [DATA_W-1:0]   key;
   logic [LEN_IN_W-1:0] key_len;
   logic [DATA_W-1:0]   value;
   logic [LEN_IN_W-1:0] val_len;

   modport source (output valid, output op, output key, output key_len,
                   output value, output val_len, input ready);
   modport sink   (input valid, input op, input key, input key_len,
                   input value, input val_len, output ready);
endinterface

`default_nettype wire

@@ design/kvt_rsp_if.sv @@
// response channel interface
`default_nettype none

interface kvt_rsp_if import kvt_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [1:0]        status;
   logic [DATA_W-1:0] read_value;
   logic [LEN_W-1:0]  read_length;

   modport source (output valid, output status, output read_value,
                   output read_length, input ready);
   modport sink   (input valid, input status, input read_value,
                   input read_length, output ready);
endinterface

`default_nettype wire

@@ design/kvt_ctrl.sv @@
// controller state machine sequencing search, update, compaction and response
`default_nettype none

module kvt_ctrl import kvt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  kvt_sts_type sts,
   output kvt_cmd_type cmd
);

   state_type      state_ff, state_in;
   op_type         op_ff, op_in;
   rsp_status_type code_ff, code_in;
   logic           rd_flag_ff, rd_flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      code_ff    <= code_in;
      rd_flag_ff <= rd_flag_in;
   end

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      code_in    = code_ff;
      rd_flag_in = rd_flag_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               rd_flag_in = 1'b0;
               code_in    = ST_OK;
               case (sts.req_op)
                  OP_PUT: begin
                     op_in = OP_PUT;
                     if (sts.req_too_long) begin
                        code_in  = ST_TOO_LONG;
                        state_in = S_RESP;
                     end else begin
                        state_in = S_SEARCH;
                     end
                  end
                  OP_GET: begin
                     op_in    = OP_GET;
                     state_in = S_SEARCH;
                  end
                  OP_DEL: begin
                     op_in    = OP_DEL;
                     state_in = S_SEARCH;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            if (sts.hit) begin
               case (op_ff)
                  OP_PUT:  state_in = S_PUT_UPD;
                  OP_GET:  state_in = S_GET_RD;
                  default: state_in = S_DEL_RD;
               endcase
            end else if (sts.miss) begin
               if (op_ff == OP_PUT) begin
                  if (sts.full) begin
                     code_in  = ST_FULL;
                     state_in = S_RESP;
                  end else begin
                     state_in = S_PUT_NEW;
                  end
               end else begin
                  code_in  = ST_NOT_FOUND;
                  state_in = S_RESP;
               end
            end
         end
         S_PUT_UPD: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WR_REQ;
            state_in   = S_RESP;
         end
         S_PUT_NEW: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_src    = WR_REQ;
            cmd.count_inc = 1'b1;
            state_in      = S_RESP;
         end
         S_GET_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_SLOT;
            rd_flag_in = 1'b1;
            state_in   = S_RESP;
         end
         S_DEL_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_LAST;
            state_in   = S_DEL_WR;
         end
         S_DEL_WR: begin
            cmd.wr_en     = 1'b1;
            cmd.wr_src    = WR_MOVE;
            cmd.count_dec = 1'b1;
            state_in      = S_RESP;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_status = code_ff;
               cmd.rsp_read   = rd_flag_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

@@ design/kvt_datapath.sv @@
// datapath: key normalization, entry memories, search compare and response register
`default_nettype none

module kvt_datapath import kvt_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          req_op,
   input  logic [DATA_W-1:0]   req_key,
   input  logic [LEN_IN_W-1:0] req_key_len,
   input  logic [DATA_W-1:0]   req_value,
   input  logic [LEN_IN_W-1:0] req_val_len,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [1:0]          rsp_status,
   output logic [DATA_W-1:0]   rsp_read_value,
   output logic [LEN_W-1:0]    rsp_read_length,
   input  kvt_cmd_type         cmd,
   output kvt_sts_type         sts
);

   logic [DATA_W-1:0] key_mem  [ENTRIES];
   logic [DATA_W-1:0] val_mem  [ENTRIES];
   logic [LEN_W-1:0]  vlen_mem [ENTRIES];

   logic [DATA_W-1:0] norm_key;
   logic [DATA_W-1:0] masked_value;

   logic [DATA_W-1:0] nkey_ff;
   logic [DATA_W-1:0] val_ff;
   logic [LEN_W-1:0]  vlen_ff;

   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  addr_ff;
   logic              cmp_vld_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic [IDX_W-1:0]  slot_ff;

   logic [DATA_W-1:0] key_rd_ff;
   logic [DATA_W-1:0] val_rd_ff;
   logic [LEN_W-1:0]  vlen_rd_ff;

   logic              rsp_valid_ff;
   rsp_status_type    rsp_status_ff;
   logic [DATA_W-1:0] rsp_value_ff;
   logic [LEN_W-1:0]  rsp_len_ff;

   logic              issue;
   logic              match;
   logic              miss;
   logic              rd_en_mem;
   logic [IDX_W-1:0]  last_idx;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] wr_key;
   logic [DATA_W-1:0] wr_val;
   logic [LEN_W-1:0]  wr_vlen;

   // key padded with spaces, value zero padded
   always_comb begin
      norm_key     = '0;
      masked_value = '0;
      for (int i = 0; i < DATA_W / 8; i++) begin
         if (i < KEY_BYTES) begin
            if (LEN_IN_W'(i) < req_key_len) begin
               norm_key[8*i +: 8] = req_key[8*i +: 8];
            end else begin
               norm_key[8*i +: 8] = PAD_BYTE;
            end
         end
         if (LEN_IN_W'(i) < req_val_len) begin
            masked_value[8*i +: 8] = req_value[8*i +: 8];
         end
      end
   end

   assign issue     = cmd.search && (addr_ff < count_ff);
   assign match     = cmp_vld_ff && (key_rd_ff == nkey_ff);
   assign miss      = !cmp_vld_ff && (addr_ff >= count_ff);
   assign rd_en_mem = issue || cmd.rd_en;
   assign last_idx  = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      if (cmd.search) begin
         rd_addr = addr_ff[IDX_W-1:0];
      end else if (cmd.rd_sel == RD_LAST) begin
         rd_addr = last_idx;
      end else begin
         rd_addr = slot_ff;
      end
   end

   assign wr_key  = (cmd.wr_src == WR_MOVE) ? key_rd_ff  : nkey_ff;
   assign wr_val  = (cmd.wr_src == WR_MOVE) ? val_rd_ff  : val_ff;
   assign wr_vlen = (cmd.wr_src == WR_MOVE) ? vlen_rd_ff : vlen_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         addr_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accept) begin
            addr_ff    <= '0;
            cmp_vld_ff <= 1'b0;
         end else if (cmd.search) begin
            cmp_vld_ff <= issue;
            if (issue) begin
               addr_ff <= addr_ff + CNT_W'(1);
            end
         end
         if (cmd.count_inc) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (cmd.count_dec) begin
            count_ff <= count_ff - CNT_W'(1);
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request and search payload
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         nkey_ff <= norm_key;
         val_ff  <= masked_value;
         vlen_ff <= req_val_len[LEN_W-1:0];
      end
      if (cmd.search) begin
         cmp_idx_ff <= addr_ff[IDX_W-1:0];
         if (match) begin
            slot_ff <= cmp_idx_ff;
         end else if (miss) begin
            slot_ff <= count_ff[IDX_W-1:0];
         end
      end
   end

   // entry memories
   always_ff @(posedge clock) begin
      if (rd_en_mem) begin
         key_rd_ff  <= key_mem[rd_addr];
         val_rd_ff  <= val_mem[rd_addr];
         vlen_rd_ff <= vlen_mem[rd_addr];
      end
      if (cmd.wr_en) begin
         key_mem[slot_ff]  <= wr_key;
         val_mem[slot_ff]  <= wr_val;
         vlen_mem[slot_ff] <= wr_vlen;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_value_ff  <= cmd.rsp_read ? val_rd_ff : '0;
         rsp_len_ff    <= cmd.rsp_read ? vlen_rd_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_value_ff;
   assign rsp_read_length = rsp_len_ff;

   assign sts.hit          = match;
   assign sts.miss         = miss;
   assign sts.full         = (count_ff == CNT_W'(ENTRIES));
   assign sts.req_op       = req_op;
   assign sts.req_too_long = (req_val_len > LEN_IN_W'(VALUE_BYTES));
   assign sts.rsp_free     = !rsp_valid_ff || rsp_ready;

endmodule

`default_nettype wire

@@ design/fixed_key_value_table_core.sv @@
// top level of the fixed-capacity key/value table core
//
//   channel  role    signals                                   transfer when
//   req_ch   sink    op key key_len value val_len              valid && ready
//   rsp_ch   source  status read_value read_length             valid && ready
//
// one request is worked at a time; the next is taken while a response waits
// the search compares one stored key per cycle from the key memory read port
// put with an overlong value and the unused op code go from idle straight to the response, with no search
// synchronous reset empties the table at once, with no clearing pass
// a stalled response holds its register and blocks only the next completion
`default_nettype none
`include "fixed_key_value_table_core_defines.svh"

module fixed_key_value_table_core import kvt_pkg::*; (
   input logic        clock,
   input logic        reset,
   kvt_req_if.sink    req_ch,
   kvt_rsp_if.source  rsp_ch
);

   kvt_cmd_type cmd;
   kvt_sts_type sts;

   kvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   kvt_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_op          (req_ch.op),
      .req_key         (req_ch.key),
      .req_key_len     (req_ch.key_len),
      .req_value       (req_ch.value),
      .req_val_len     (req_ch.val_len),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_status      (rsp_ch.status),
      .rsp_read_value  (rsp_ch.read_value),
      .rsp_read_length (rsp_ch.read_length),
      .cmd             (cmd),
      .sts             (sts)
   );

   `KVT_ASSERT(a_one_request_at_a_time, req_ch.valid && req_ch.ready |=> !req_ch.ready)
   `KVT_ASSERT(a_rsp_not_overwritten, cmd.rsp_load |-> sts.rsp_free)
   `KVT_ASSERT_NEVER(a_no_append_when_full, cmd.count_inc && sts.full)

endmodule

`default_nettype wire
